/* design/csma_tx_pkg.sv */
// csma_tx_pkg: shared types, codes and constants of the csma/cd transmit controller
// no dependencies; used by every module of the block by scoped names
package csma_tx_pkg;

    localparam int unsigned MaxExponent  = 10;
    localparam int unsigned RandWidth    = 10;
    localparam int unsigned CountWidth   = 8;
    localparam int unsigned IdleWidth    = 9;
    localparam int unsigned WaitWidth    = 22;
    localparam int unsigned PhaseWidth   = 3;
    localparam int unsigned OutTdataWidth = 16;

    localparam logic [IdleWidth-1:0]  IdleSaturated = 9'd256;
    localparam logic [CountWidth-1:0] CountMax      = 8'd255;

    // phase codes as shown on the result stream
    localparam logic [PhaseWidth-1:0] PhaseIdle    = 3'd0;
    localparam logic [PhaseWidth-1:0] PhaseDefer   = 3'd1;
    localparam logic [PhaseWidth-1:0] PhaseTx      = 3'd2;
    localparam logic [PhaseWidth-1:0] PhaseJam     = 3'd3;
    localparam logic [PhaseWidth-1:0] PhaseBackoff = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CfgGapBits    = 2'd0;
    localparam logic [1:0] CfgJamBits    = 2'd1;
    localparam logic [1:0] CfgSlotBits   = 2'd2;
    localparam logic [1:0] CfgBackoffCap = 2'd3;

    localparam logic [7:0]  GapBitsReset    = 8'd96;
    localparam logic [7:0]  JamBitsReset    = 8'd32;
    localparam logic [11:0] SlotBitsReset   = 12'd512;
    localparam logic [3:0]  BackoffCapReset = 4'd10;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_DEFER   = 5'b00010,
        ST_TX      = 5'b00100,
        ST_JAM     = 5'b01000,
        ST_BACKOFF = 5'b10000
    } state_t;

    typedef struct packed {
        logic [7:0]  gap_bits;
        logic [7:0]  jam_bits;
        logic [11:0] slot_bits;
        logic [3:0]  backoff_cap;
    } cfg_t;

    typedef struct packed {
        logic                 packet_ready;
        logic                 carrier;
        logic                 collision;
        logic [RandWidth-1:0] random_bits;
    } in_flags_t;

    typedef struct packed {
        logic                  take_packet;
        logic                  tx_active;
        logic                  jam_active;
        logic                  packet_sent;
        logic [CountWidth-1:0] attempt_count;
        logic [PhaseWidth-1:0] phase;
    } result_t;

    typedef struct packed {
        logic step;
        logic out_free;
    } flow_t;

endpackage

/* design/csma_tx_cfg.sv */
// csma_tx_cfg: configuration registers written through the plain write port
// depends on csma_tx_pkg
module csma_tx_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [11:0]         cfg_wdata,
    output csma_tx_pkg::cfg_t   cfg
);

    csma_tx_pkg::cfg_t cfg_reg;
    csma_tx_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                csma_tx_pkg::CfgGapBits:    cfg_next.gap_bits    = cfg_wdata[7:0];
                csma_tx_pkg::CfgJamBits:    cfg_next.jam_bits    = cfg_wdata[7:0];
                csma_tx_pkg::CfgSlotBits:   cfg_next.slot_bits   = cfg_wdata;
                csma_tx_pkg::CfgBackoffCap: cfg_next.backoff_cap = cfg_wdata[3:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_bits    <= csma_tx_pkg::GapBitsReset;
            cfg_reg.jam_bits    <= csma_tx_pkg::JamBitsReset;
            cfg_reg.slot_bits   <= csma_tx_pkg::SlotBitsReset;
            cfg_reg.backoff_cap <= csma_tx_pkg::BackoffCapReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/csma_tx_in_stage.sv */
// csma_tx_in_stage: input register holding one bit-time transaction
// depends on csma_tx_pkg
module csma_tx_in_stage #(
    parameter int unsigned LENGTH_WIDTH = 14
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  csma_tx_pkg::in_flags_t      in_flags,
    input  logic [LENGTH_WIDTH-1:0]     in_length,
    input  csma_tx_pkg::flow_t          flow,
    output logic                        hold_valid,
    output csma_tx_pkg::in_flags_t      hold_flags,
    output logic [LENGTH_WIDTH-1:0]     hold_length
);

    logic                       valid_reg;
    logic                       valid_next;
    csma_tx_pkg::in_flags_t     flags_reg;
    logic [LENGTH_WIDTH-1:0]    length_reg;
    logic                       load;

    assign s_tready = !valid_reg || flow.out_free;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (flow.step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg  <= in_flags;
            length_reg <= in_length;
        end
    end

    assign hold_valid  = valid_reg;
    assign hold_flags  = flags_reg;
    assign hold_length = length_reg;

endmodule

/* design/csma_tx_core.sv */
// csma_tx_core: transmit state machine, idle/bit/wait counters and backoff draw
// depends on csma_tx_pkg; advances one bit time per step
module csma_tx_core #(
    parameter int unsigned LENGTH_WIDTH = 14
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  csma_tx_pkg::in_flags_t      flags,
    input  logic [LENGTH_WIDTH-1:0]     length,
    input  csma_tx_pkg::cfg_t           cfg,
    output csma_tx_pkg::result_t        result
);

    localparam int unsigned CW = csma_tx_pkg::CountWidth;
    localparam int unsigned IW = csma_tx_pkg::IdleWidth;
    localparam int unsigned WW = csma_tx_pkg::WaitWidth;
    localparam int unsigned RW = csma_tx_pkg::RandWidth;
    localparam logic [3:0] ExpLimit =
        4'((csma_tx_pkg::MaxExponent < RW) ? csma_tx_pkg::MaxExponent : RW);

    csma_tx_pkg::state_t        state_reg, state_next;
    logic [CW-1:0]              collisions_reg, collisions_next;
    logic [IW-1:0]              idle_count_reg, idle_count_next;
    logic [LENGTH_WIDTH-1:0]    bit_count_reg, bit_count_next;
    logic [LENGTH_WIDTH-1:0]    length_reg, length_next;
    logic [WW-1:0]              wait_count_reg, wait_count_next;

    logic [CW-1:0]              coll_inc;
    logic [CW-1:0]              draw_coll;
    logic [3:0]                 cap_eff;
    logic [3:0]                 draw_exp;
    logic [RW-1:0]              slot_mask;
    logic [RW-1:0]              slots;
    logic [WW-1:0]              draw_wait;
    logic [WW-1:0]              wait_dec;
    logic [LENGTH_WIDTH-1:0]    bit_inc;

    assign coll_inc = (collisions_reg < csma_tx_pkg::CountMax) ?
                      collisions_reg + 1'b1 : collisions_reg;

    // in transmit the draw sees the count that already includes this collision
    assign draw_coll = (state_reg == csma_tx_pkg::ST_TX) ? coll_inc : collisions_reg;
    assign cap_eff   = (cfg.backoff_cap > ExpLimit) ? ExpLimit : cfg.backoff_cap;
    assign draw_exp  = (draw_coll > {{(CW-4){1'b0}}, cap_eff}) ? cap_eff : draw_coll[3:0];
    assign slot_mask = ~({RW{1'b1}} << draw_exp);
    assign slots     = flags.random_bits & slot_mask;
    assign draw_wait = WW'(slots) * WW'(cfg.slot_bits);

    assign wait_dec  = (wait_count_reg != '0) ? wait_count_reg - 1'b1 : wait_count_reg;
    assign bit_inc   = bit_count_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        collisions_next = collisions_reg;
        bit_count_next  = bit_count_reg;
        length_next     = length_reg;
        wait_count_next = wait_count_reg;
        result          = '0;

        if (flags.carrier)
        begin
            idle_count_next = '0;
        end
        else if (idle_count_reg < csma_tx_pkg::IdleSaturated)
        begin
            idle_count_next = idle_count_reg + 1'b1;
        end
        else
        begin
            idle_count_next = idle_count_reg;
        end

        unique case (state_reg)
            csma_tx_pkg::ST_DEFER:
            begin
                result.phase = csma_tx_pkg::PhaseDefer;
                if (!flags.carrier && (idle_count_next >= {1'b0, cfg.gap_bits}))
                begin
                    bit_count_next = '0;
                    state_next     = csma_tx_pkg::ST_TX;
                end
            end
            csma_tx_pkg::ST_TX:
            begin
                result.phase = csma_tx_pkg::PhaseTx;
                if (flags.collision)
                begin
                    collisions_next = coll_inc;
                    if (cfg.jam_bits == '0)
                    begin
                        wait_count_next = draw_wait;
                        state_next = (draw_wait == '0) ? csma_tx_pkg::ST_DEFER :
                                                         csma_tx_pkg::ST_BACKOFF;
                    end
                    else
                    begin
                        wait_count_next = WW'(cfg.jam_bits);
                        state_next      = csma_tx_pkg::ST_JAM;
                    end
                end
                else
                begin
                    result.tx_active = 1'b1;
                    bit_count_next   = bit_inc;
                    if (bit_inc >= length_reg)
                    begin
                        result.packet_sent = 1'b1;
                        state_next         = csma_tx_pkg::ST_IDLE;
                    end
                end
            end
            csma_tx_pkg::ST_JAM:
            begin
                result.phase      = csma_tx_pkg::PhaseJam;
                result.jam_active = 1'b1;
                wait_count_next   = wait_dec;
                if (wait_dec == '0)
                begin
                    wait_count_next = draw_wait;
                    state_next = (draw_wait == '0) ? csma_tx_pkg::ST_DEFER :
                                                     csma_tx_pkg::ST_BACKOFF;
                end
            end
            csma_tx_pkg::ST_BACKOFF:
            begin
                result.phase    = csma_tx_pkg::PhaseBackoff;
                wait_count_next = wait_dec;
                if (wait_dec == '0)
                begin
                    state_next = csma_tx_pkg::ST_DEFER;
                end
            end
            default:
            begin
                result.phase = csma_tx_pkg::PhaseIdle;
                state_next   = csma_tx_pkg::ST_IDLE;
                if (flags.packet_ready)
                begin
                    result.take_packet = 1'b1;
                    length_next        = length;
                    collisions_next    = '0;
                    state_next         = csma_tx_pkg::ST_DEFER;
                end
            end
        endcase

        result.attempt_count = collisions_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= csma_tx_pkg::ST_IDLE;
            collisions_reg <= '0;
            idle_count_reg <= csma_tx_pkg::IdleSaturated;
            bit_count_reg  <= '0;
            length_reg     <= '0;
            wait_count_reg <= '0;
        end
        else if (step)
        begin
            state_reg      <= state_next;
            collisions_reg <= collisions_next;
            idle_count_reg <= idle_count_next;
            bit_count_reg  <= bit_count_next;
            length_reg     <= length_next;
            wait_count_reg <= wait_count_next;
        end
    end

endmodule

/* design/csma_tx_out_stage.sv */
// csma_tx_out_stage: result register on the master side of the stream
// depends on csma_tx_pkg
module csma_tx_out_stage
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  csma_tx_pkg::result_t    result,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output csma_tx_pkg::result_t    result_out,
    output logic                    out_free
);

    logic                   valid_reg;
    logic                   valid_next;
    csma_tx_pkg::result_t   result_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (step)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid   = valid_reg;
    assign result_out = result_reg;

endmodule

/* design/csma_cd_transmit_control_unit.sv */
// csma_cd_transmit_control_unit: top level of the csma/cd transmit controller
// depends on csma_tx_pkg, csma_tx_cfg, csma_tx_in_stage, csma_tx_core, csma_tx_out_stage
//
// Each input transaction is one bit time on the link and yields exactly one result
// transaction. A transaction goes from the input register through the state machine
// and the backoff draw (one 10 x 12 multiply) into the result register, which drives
// m_tdata and loads once the master side is free. One new bit is accepted every
// cycle while results are taken; a stall on the master side holds both registers,
// so the throughput is limited by the master side taking results. The controller
// idles, takes a waiting packet, defers for the inter-frame gap, transmits, jams on
// a collision and backs off a random number of slots before it retries. The user
// must write configuration only while no transaction is in flight; no check in the block.
module csma_cd_transmit_control_unit #(
    parameter int unsigned LENGTH_WIDTH = 14
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [1:0]                                  cfg_addr,
    input  logic [11:0]                                 cfg_wdata,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // packet_ready, packet_bits, carrier, collision, random_bits, zero fill
    input  logic [(((LENGTH_WIDTH+13)+7)/8)*8-1:0]      s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // take_packet, tx_active, jam_active, packet_sent, attempt_count, phase, zero fill
    output logic [csma_tx_pkg::OutTdataWidth-1:0]       m_tdata
);

    localparam int unsigned CarrierBit = LENGTH_WIDTH + 1;
    localparam int unsigned CollBit    = LENGTH_WIDTH + 2;
    localparam int unsigned RandLo     = LENGTH_WIDTH + 3;
    localparam int unsigned InBits     = LENGTH_WIDTH + 13;
    localparam int unsigned InTdata    = ((InBits + 7) / 8) * 8;

    csma_tx_pkg::cfg_t          cfg;
    csma_tx_pkg::in_flags_t     in_flags;
    logic [LENGTH_WIDTH-1:0]    in_length;
    csma_tx_pkg::flow_t         flow;
    logic                       hold_valid;
    csma_tx_pkg::in_flags_t     hold_flags;
    logic [LENGTH_WIDTH-1:0]    hold_length;
    csma_tx_pkg::result_t       core_result;
    csma_tx_pkg::result_t       result_out;
    logic                       out_free;
    logic [InTdata-InBits-1:0]  unused_fill;

    assign in_flags.packet_ready = s_tdata[0];
    assign in_length             = s_tdata[LENGTH_WIDTH:1];
    assign in_flags.carrier      = s_tdata[CarrierBit];
    assign in_flags.collision    = s_tdata[CollBit];
    assign in_flags.random_bits  = s_tdata[RandLo +: csma_tx_pkg::RandWidth];
    assign unused_fill           = s_tdata[InTdata-1:InBits];

    assign flow.out_free = out_free;
    assign flow.step     = hold_valid && out_free;

    csma_tx_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    csma_tx_in_stage #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_flags    (in_flags),
        .in_length   (in_length),
        .flow        (flow),
        .hold_valid  (hold_valid),
        .hold_flags  (hold_flags),
        .hold_length (hold_length)
    );

    csma_tx_core #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (flow.step),
        .flags  (hold_flags),
        .length (hold_length),
        .cfg    (cfg),
        .result (core_result)
    );

    csma_tx_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (flow.step),
        .result     (core_result),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result_out (result_out),
        .out_free   (out_free)
    );

    // fill bits on the slave side carry nothing
    assign m_tdata = {(unused_fill != '0) & 1'b0,
                      result_out.phase,
                      result_out.attempt_count,
                      result_out.packet_sent,
                      result_out.jam_active,
                      result_out.tx_active,
                      result_out.take_packet};

endmodule

/* design/csma_tx_checker.sv */
// csma_tx_checker: port-level checks on the result stream of the transmit controller
// depends on csma_tx_pkg; bound to csma_cd_transmit_control_unit below
module csma_tx_checker
(
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    m_tvalid,
    input logic                                    m_tready,
    input logic [csma_tx_pkg::OutTdataWidth-1:0]   m_tdata
);

    logic                                  take_packet;
    logic                                  tx_active;
    logic                                  jam_active;
    logic                                  packet_sent;
    logic [csma_tx_pkg::PhaseWidth-1:0]    phase;

    assign take_packet = m_tdata[0];
    assign tx_active   = m_tdata[1];
    assign jam_active  = m_tdata[2];
    assign packet_sent = m_tdata[3];
    assign phase       = m_tdata[14:12];

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && take_packet |-> phase == csma_tx_pkg::PhaseIdle)
        else $error("packet taken outside idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && packet_sent |-> tx_active && phase == csma_tx_pkg::PhaseTx)
        else $error("packet released without a transmitted bit");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && jam_active |-> !tx_active && phase == csma_tx_pkg::PhaseJam)
        else $error("jam outside jam phase");

endmodule

bind csma_cd_transmit_control_unit csma_tx_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking bench for csma_cd_transmit_control_unit, one transaction per bit time
// depends on csma_tx_pkg and the block rtl; a local predictor or typed row gives expected results
module tb;
    import csma_tx_pkg::*;

    localparam int ClkPeriod   = 4;
    localparam int DrainCycles = 8;
    localparam int CycleLimit  = 600000;

    typedef struct packed {
        logic        ready;
        logic [13:0] len;
        logic        carrier;
        logic        collision;
        logic [9:0]  rnd;
    } link_bit_t;

    typedef struct packed {
        logic        is_reg;
        logic [1:0]  reg_idx;
        logic [11:0] reg_value;
        link_bit_t   stim;
        logic        typed;
        result_t     want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [11:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    // predictor state
    cfg_t         cfg_model;
    logic [2:0]   link_phase;
    logic [7:0]   attempts;
    logic [8:0]   quiet_bits;
    logic [13:0]  sent_bits;
    logic [13:0]  pkt_len;
    logic [21:0]  wait_left;

    result_t      pending_results[$];
    stim_row_t    directed_rows[$];
    int unsigned  mismatches;
    int unsigned  cycle_count;
    bit           tx_gaps;
    bit           rx_stalls;
    result_t      got;
    result_t      want;

    csma_cd_transmit_control_unit #(
        .LENGTH_WIDTH(14)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t: %s", $time, what);
    endtask

    function automatic void start_backoff(logic [9:0] rnd);
        int unsigned exp_limit;
        int unsigned exponent;
        logic [9:0]  window;
        exp_limit = cfg_model.backoff_cap;
        if (exp_limit > MaxExponent)
        begin
            exp_limit = MaxExponent;
        end
        exponent = attempts;
        if (exponent > exp_limit)
        begin
            exponent = exp_limit;
        end
        window = 10'((1 << exponent) - 1);
        wait_left = 22'(int'(rnd & window) * int'(cfg_model.slot_bits));
        link_phase = (wait_left == '0) ? PhaseDefer : PhaseBackoff;
    endfunction

    // one bit time of the controller, updates the predictor state
    function automatic result_t predict_bit(link_bit_t b);
        result_t r;
        r = '0;
        r.phase = link_phase;
        // the idle count moves before the defer decision of the same bit
        if (b.carrier)
        begin
            quiet_bits = '0;
        end
        else if (quiet_bits < IdleSaturated)
        begin
            quiet_bits++;
        end
        case (link_phase)
            PhaseDefer:
            begin
                if (!b.carrier && quiet_bits >= cfg_model.gap_bits)
                begin
                    sent_bits = '0;
                    link_phase = PhaseTx;
                end
            end
            PhaseTx:
            begin
                if (b.collision)
                begin
                    if (attempts < CountMax)
                    begin
                        attempts++;
                    end
                    // no jam at all: the backoff is drawn in the collision bit
                    if (cfg_model.jam_bits == '0)
                    begin
                        start_backoff(b.rnd);
                    end
                    else
                    begin
                        wait_left = 22'(cfg_model.jam_bits);
                        link_phase = PhaseJam;
                    end
                end
                else
                begin
                    r.tx_active = 1'b1;
                    sent_bits++;
                    if (sent_bits >= pkt_len)
                    begin
                        r.packet_sent = 1'b1;
                        link_phase = PhaseIdle;
                    end
                end
            end
            PhaseJam:
            begin
                r.jam_active = 1'b1;
                if (wait_left > 0)
                begin
                    wait_left--;
                end
                if (wait_left == '0)
                begin
                    start_backoff(b.rnd);
                end
            end
            PhaseBackoff:
            begin
                if (wait_left > 0)
                begin
                    wait_left--;
                end
                if (wait_left == '0)
                begin
                    link_phase = PhaseDefer;
                end
            end
            default:
            begin
                r.phase = PhaseIdle;
                link_phase = PhaseIdle;
                if (b.ready)
                begin
                    r.take_packet = 1'b1;
                    pkt_len = b.len;
                    attempts = '0;
                    link_phase = PhaseDefer;
                end
            end
        endcase
        r.attempt_count = attempts;
        return r;
    endfunction

    function automatic stim_row_t link_row(int unsigned ready, int unsigned len,
                                           int unsigned carrier, int unsigned coll,
                                           int unsigned rnd);
        stim_row_t r;
        r = '0;
        r.stim.ready = 1'(ready);
        r.stim.len = 14'(len);
        r.stim.carrier = 1'(carrier);
        r.stim.collision = 1'(coll);
        r.stim.rnd = 10'(rnd);
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [1:0] idx, logic [11:0] value);
        stim_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_value = value;
        return r;
    endfunction

    // rows whose result is plain from the reset state
    function automatic stim_row_t with_result(stim_row_t row, int unsigned take,
                                              int unsigned tx, int unsigned sent,
                                              logic [2:0] ph);
        stim_row_t r;
        r = row;
        r.typed = 1'b1;
        r.want = '0;
        r.want.take_packet = 1'(take);
        r.want.tx_active = 1'(tx);
        r.want.packet_sent = 1'(sent);
        r.want.phase = ph;
        return r;
    endfunction

    task automatic wait_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        wait_results();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        case (idx)
            CfgGapBits:    cfg_model.gap_bits = value[7:0];
            CfgJamBits:    cfg_model.jam_bits = value[7:0];
            CfgSlotBits:   cfg_model.slot_bits = value;
            CfgBackoffCap: cfg_model.backoff_cap = value[3:0];
            default:       ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_bit(input link_bit_t b, input logic typed, input result_t typed_want);
        int unsigned gap;
        result_t     predicted;
        gap = tx_gaps ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, b.rnd, b.collision, b.carrier, b.len, b.ready};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = predict_bit(b);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    // result side: random stalls per transaction
    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_stalls ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.take_packet = m_tdata[0];
            got.tx_active = m_tdata[1];
            got.jam_active = m_tdata[2];
            got.packet_sent = m_tdata[3];
            got.attempt_count = m_tdata[11:4];
            got.phase = m_tdata[14:12];
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result transaction %h", m_tdata));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.take_packet !== want.take_packet)
                    report_mismatch($sformatf("take_packet %b, expected %b",
                                              got.take_packet, want.take_packet));
                if (got.tx_active !== want.tx_active)
                    report_mismatch($sformatf("tx_active %b, expected %b",
                                              got.tx_active, want.tx_active));
                if (got.jam_active !== want.jam_active)
                    report_mismatch($sformatf("jam_active %b, expected %b",
                                              got.jam_active, want.jam_active));
                if (got.packet_sent !== want.packet_sent)
                    report_mismatch($sformatf("packet_sent %b, expected %b",
                                              got.packet_sent, want.packet_sent));
                if (got.attempt_count !== want.attempt_count)
                    report_mismatch($sformatf("attempt_count %0d, expected %0d",
                                              got.attempt_count, want.attempt_count));
                if (got.phase !== want.phase)
                    report_mismatch($sformatf("phase %0d, expected %0d", got.phase, want.phase));
            end
        end
    end

    initial
    begin
        int unsigned p;
        int unsigned k;
        int unsigned items;
        int unsigned carrier_pct;
        int unsigned coll_pct;
        link_bit_t   b;
        logic [7:0]  gap;
        logic [7:0]  jam;
        logic [11:0] slot;
        logic [3:0]  cap;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatches = 0;
        cycle_count = 0;
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        cfg_model = '{GapBitsReset, JamBitsReset, SlotBitsReset, BackoffCapReset};
        link_phase = PhaseIdle;
        attempts = '0;
        quiet_bits = IdleSaturated;
        sent_bits = '0;
        pkt_len = '0;
        wait_left = '0;

        // reset state: a long silent bus lets the first packet go straight out
        directed_rows.push_back(with_result(link_row(0, 0, 0, 0, 0), 0, 0, 0, PhaseIdle));
        // zero length, collision ignored while idle
        directed_rows.push_back(with_result(link_row(1, 0, 0, 1, 1023), 1, 0, 0, PhaseIdle));
        // packet_ready ignored outside idle
        directed_rows.push_back(with_result(link_row(1, 16383, 0, 0, 0), 0, 0, 0, PhaseDefer));
        // a zero length packet goes out as one bit
        directed_rows.push_back(with_result(link_row(0, 0, 0, 0, 0), 0, 1, 1, PhaseTx));
        // upper bits of the write data are dropped
        directed_rows.push_back(reg_row(CfgGapBits, 12'hF02));
        directed_rows.push_back(reg_row(CfgJamBits, 12'h000));
        directed_rows.push_back(reg_row(CfgSlotBits, 12'd1));
        directed_rows.push_back(reg_row(CfgBackoffCap, 12'h00F));
        directed_rows.push_back(link_row(1, 3, 0, 0, 0));
        // carrier during the gap restarts the wait
        directed_rows.push_back(link_row(0, 0, 1, 0, 0));
        directed_rows.push_back(link_row(0, 0, 0, 0, 0));
        directed_rows.push_back(link_row(0, 0, 1, 0, 0));
        directed_rows.push_back(link_row(0, 0, 0, 0, 0));
        directed_rows.push_back(link_row(0, 0, 0, 0, 0));
        // collision with no jam: backoff drawn in the same bit
        directed_rows.push_back(link_row(0, 0, 0, 1, 1023));
        directed_rows.push_back(link_row(1, 0, 1, 1, 0));
        directed_rows.push_back(link_row(0, 0, 0, 0, 0));
        directed_rows.push_back(link_row(0, 0, 0, 0, 0));
        // zero slots: straight back to defer
        directed_rows.push_back(link_row(0, 0, 0, 1, 0));
        directed_rows.push_back(link_row(0, 0, 0, 0, 0));
        directed_rows.push_back(link_row(0, 0, 0, 0, 0));
        directed_rows.push_back(link_row(0, 0, 0, 0, 0));
        directed_rows.push_back(link_row(0, 0, 0, 0, 0));
        directed_rows.push_back(link_row(0, 0, 0, 0, 0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_reg)
            begin
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_value);
            end
            else
            begin
                send_bit(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (p = 0; p < 8; p++)
        begin
            items = 130;
            case (p)
                0:
                begin
                    gap = 8'd0; jam = 8'd0; slot = 12'd1; cap = 4'd0;
                    carrier_pct = 10; coll_pct = 4;
                end
                1:
                begin
                    gap = 8'd255; jam = 8'd255; slot = 12'd4095; cap = 4'd0;
                    carrier_pct = 0; coll_pct = 5;
                end
                2:
                begin
                    gap = 8'($urandom_range(0, 24)); jam = 8'($urandom_range(1, 12));
                    slot = 12'd1; cap = 4'd15;
                    carrier_pct = 5; coll_pct = 10;
                end
                3:
                begin
                    // slot length of zero gives no backoff at all
                    gap = 8'($urandom_range(0, 24)); jam = 8'($urandom_range(0, 12));
                    slot = 12'd0; cap = 4'd10;
                    carrier_pct = 5; coll_pct = 10;
                end
                4:
                begin
                    // every transmit bit collides so the attempt count saturates
                    gap = 8'd0; jam = 8'd0; slot = 12'd1; cap = 4'd0;
                    carrier_pct = 0; coll_pct = 100; items = 700;
                end
                5:
                begin
                    gap = GapBitsReset; jam = JamBitsReset; slot = SlotBitsReset; cap = 4'd1;
                    carrier_pct = 2; coll_pct = 3;
                end
                6:
                begin
                    gap = 8'($urandom_range(0, 16)); jam = 8'($urandom_range(0, 8));
                    slot = 12'($urandom_range(1, 16)); cap = 4'($urandom_range(0, 4));
                    carrier_pct = 8; coll_pct = 6;
                end
                default:
                begin
                    gap = 8'($urandom_range(0, 40)); jam = 8'($urandom_range(0, 255));
                    slot = 12'($urandom_range(1, 4095)); cap = 4'($urandom_range(0, 1));
                    carrier_pct = 5; coll_pct = 6;
                end
            endcase
            write_reg(CfgGapBits, {4'($urandom), gap});
            write_reg(CfgJamBits, {4'($urandom), jam});
            write_reg(CfgSlotBits, slot);
            write_reg(CfgBackoffCap, {8'($urandom), cap});
            tx_gaps = (p % 2) == 0;
            rx_stalls = (p % 3) != 1;

            for (k = 0; k < items; k++)
            begin
                if (k == items / 2)
                begin
                    wait_results();
                end
                b.ready = (link_phase == PhaseIdle) ? ($urandom_range(0, 3) != 0)
                                                    : 1'($urandom_range(0, 1));
                // mostly short packets; the length only matters when a packet is taken
                if (link_phase != PhaseIdle)
                    b.len = 14'($urandom_range(0, 16383));
                else if ($urandom_range(0, 9) == 0)
                    b.len = 14'($urandom_range(41, 400));
                else
                    b.len = 14'($urandom_range(0, 40));
                b.carrier = $urandom_range(0, 99) < carrier_pct;
                b.collision = (link_phase == PhaseTx) ? ($urandom_range(0, 99) < coll_pct)
                                                      : 1'($urandom_range(0, 1));
                b.rnd = 10'($urandom_range(0, 1023));
                send_bit(b, 1'b0, '0);
            end
        end

        wait_results();
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
